FILE: rtl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and constants for the pixel layer blend block: blend mode
// codes, register indexes, per-channel operation codes and the control
// bundle handed to each channel datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  // Pixel and alpha widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned AlphaW  = 9;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 9;

  // Full layer weight and the rounding constant for a >> 8
  localparam logic [AlphaW-1:0] ALPHA_ONE  = 9'd256;
  localparam logic [16:0]       ROUND_HALF = 17'd128;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_BLEND_MODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_LEVEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MARK_VALUE  = 2'd2;

  // Register reset values
  localparam logic [ModeW-1:0]  BLEND_MODE_RST  = 3'd2;
  localparam logic [AlphaW-1:0] ALPHA_LEVEL_RST = 9'd128;
  localparam logic [ChanW-1:0]  MARK_VALUE_RST  = 8'd255;

  // Blend mode codes for the selection pass
  localparam logic [ModeW-1:0] BLEND_MARK   = 3'd0;
  localparam logic [ModeW-1:0] BLEND_ALPHA1 = 3'd1;
  localparam logic [ModeW-1:0] BLEND_ALPHA2 = 3'd2;
  localparam logic [ModeW-1:0] BLEND_ALPHA3 = 3'd3;
  localparam logic [ModeW-1:0] BLEND_OR     = 3'd4;
  localparam logic [ModeW-1:0] BLEND_OR_MAX = 3'd5;

  // Pass selector on the func input
  localparam logic FUNC_HIDDEN = 1'b0;

  // Operation applied by each channel datapath
  typedef enum logic [2:0] {
    OP_PASS,
    OP_MARK,
    OP_ALPHA,
    OP_OR,
    OP_MAX
  } plb_op_e;

  // Per-pixel control handed to the channel datapaths
  typedef struct packed {
    plb_op_e            op;
    logic [AlphaW-1:0]  alpha;
    logic [ChanW-1:0]   mark;
  } plb_ctrl_t;

endpackage : plb_pkg

`default_nettype wire

FILE: rtl/plb_channel.sv
// ----------------------------------------------------------------------------
// plb_channel
// Datapath for one colour channel: pass, mark, alpha blend with rounding,
// OR, or max against the alpha-scaled layer value.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_channel (
  input  wire plb_pkg::plb_ctrl_t         ctrl_i,
  input  wire logic [plb_pkg::ChanW-1:0]  acc_i,
  input  wire logic [plb_pkg::ChanW-1:0]  layer_i,
  output logic      [plb_pkg::ChanW-1:0]  out_o
);
  import plb_pkg::*;

  logic [AlphaW-1:0] base_weight;
  logic [16:0]       prod_acc;
  logic [16:0]       prod_layer;
  logic [16:0]       blend_sum;
  logic [16:0]       scaled_sum;
  logic [ChanW-1:0]  blend_val;
  logic [ChanW-1:0]  scaled_val;

  // Weighted sum of running and layer values, rounded half up
  assign base_weight = ALPHA_ONE - ctrl_i.alpha;
  assign prod_acc    = {9'd0, acc_i} * {8'd0, base_weight};
  assign prod_layer  = {9'd0, layer_i} * {8'd0, ctrl_i.alpha};
  assign blend_sum   = prod_acc + prod_layer + ROUND_HALF;
  assign scaled_sum  = prod_layer + ROUND_HALF;
  assign blend_val   = blend_sum[15:8];
  assign scaled_val  = scaled_sum[15:8];

  // Select the channel result
  always_comb begin
    case (ctrl_i.op)
      OP_MARK:  out_o = ctrl_i.mark;
      OP_ALPHA: out_o = blend_val;
      OP_OR:    out_o = acc_i | layer_i;
      OP_MAX: begin
        if ((layer_i != '0) && (scaled_val > acc_i)) begin
          out_o = scaled_val;
        end else begin
          out_o = acc_i;
        end
      end
      default:  out_o = acc_i;
    endcase
  end

endmodule : plb_channel

`default_nettype wire

FILE: rtl/pixel_layer_blend.sv
// Each accepted pixel passes through the input register and then the result register.
// Throughput: one pixel per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on out_ready_i.
// Reset: rst_ni clears both stage valid flags and loads blend_mode 2,
// alpha_level 128 and mark_value 255.
// ----------------------------------------------------------------------------
// pixel_layer_blend
// Per-pixel RGB layer compositor: registers one pixel, decodes the pass and
// blend mode, runs three channel datapaths and registers the new pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_layer_blend (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [plb_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [plb_pkg::CfgDatW-1:0]     cfg_data_i,
  // input channel
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            func_i,
  input  wire logic [plb_pkg::ChanW-1:0]       base_red_i,
  input  wire logic [plb_pkg::ChanW-1:0]       base_green_i,
  input  wire logic [plb_pkg::ChanW-1:0]       base_blue_i,
  input  wire logic [plb_pkg::ChanW-1:0]       acc_red_i,
  input  wire logic [plb_pkg::ChanW-1:0]       acc_green_i,
  input  wire logic [plb_pkg::ChanW-1:0]       acc_blue_i,
  input  wire logic [plb_pkg::ChanW-1:0]       layer_red_i,
  input  wire logic [plb_pkg::ChanW-1:0]       layer_green_i,
  input  wire logic [plb_pkg::ChanW-1:0]       layer_blue_i,
  // output channel
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [plb_pkg::ChanW-1:0]       out_red_o,
  output logic      [plb_pkg::ChanW-1:0]       out_green_o,
  output logic      [plb_pkg::ChanW-1:0]       out_blue_o
);
  import plb_pkg::*;

  // Configuration registers
  logic [ModeW-1:0]  blend_mode_q;
  logic [AlphaW-1:0] alpha_level_q;
  logic [ChanW-1:0]  mark_value_q;

  // Input stage
  logic              s1_valid_q;
  logic              func_q;
  logic [ChanW-1:0]  base_q  [3];
  logic [ChanW-1:0]  acc_q   [3];
  logic [ChanW-1:0]  layer_q [3];

  // Result stage
  logic              s2_valid_q;
  logic [ChanW-1:0]  res_q [3];
  logic [ChanW-1:0]  res_d [3];

  logic              in_xfer;
  logic              s1_advance;
  logic              base_black;
  logic              layer_on;
  logic [AlphaW-1:0] eff_alpha;
  plb_op_e           op;
  plb_ctrl_t         ctrl;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q  <= BLEND_MODE_RST;
      alpha_level_q <= ALPHA_LEVEL_RST;
      mark_value_q  <= MARK_VALUE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLEND_MODE:  blend_mode_q  <= cfg_data_i[ModeW-1:0];
        CFG_ALPHA_LEVEL: alpha_level_q <= cfg_data_i[AlphaW-1:0];
        CFG_MARK_VALUE:  mark_value_q  <= cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: advance stage one whenever the result stage frees up
  assign s1_advance = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  // Capture the input pixel
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q     <= func_i;
      base_q[0]  <= base_red_i;
      base_q[1]  <= base_green_i;
      base_q[2]  <= base_blue_i;
      acc_q[0]   <= acc_red_i;
      acc_q[1]   <= acc_green_i;
      acc_q[2]   <= acc_blue_i;
      layer_q[0] <= layer_red_i;
      layer_q[1] <= layer_green_i;
      layer_q[2] <= layer_blue_i;
    end
  end

  // Pixel-wide conditions and saturated alpha
  assign base_black = (base_q[0] | base_q[1] | base_q[2]) == '0;
  assign layer_on   = (layer_q[0] | layer_q[1] | layer_q[2]) != '0;
  assign eff_alpha  = (alpha_level_q > ALPHA_ONE) ? ALPHA_ONE : alpha_level_q;

  // Decode pass and blend mode into one channel operation
  always_comb begin
    op = OP_PASS;
    if (func_q == FUNC_HIDDEN) begin
      op = (base_black && layer_on) ? OP_MARK : OP_PASS;
    end else begin
      unique case (blend_mode_q) inside
        BLEND_MARK: begin
          op = (base_black && layer_on) ? OP_MARK : OP_PASS;
        end
        BLEND_ALPHA1, BLEND_ALPHA2, BLEND_ALPHA3: begin
          op = layer_on ? OP_ALPHA : OP_PASS;
        end
        BLEND_OR: begin
          op = OP_OR;
        end
        BLEND_OR_MAX: begin
          if (base_black) begin
            op = OP_OR;
          end else if (layer_on) begin
            op = OP_MAX;
          end else begin
            op = OP_PASS;
          end
        end
        default: op = OP_PASS;
      endcase
    end
  end

  assign ctrl = '{op: op, alpha: eff_alpha, mark: mark_value_q};

  // Channel datapaths
  for (genvar c = 0; c < 3; c++) begin : g_chan
    plb_channel u_chan (
      .ctrl_i  (ctrl),
      .acc_i   (acc_q[c]),
      .layer_i (layer_q[c]),
      .out_o   (res_d[c])
    );
  end

  // Hold the result until transferred
  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_red_o   = res_q[0];
  assign out_green_o = res_q[1];
  assign out_blue_o  = res_q[2];

endmodule : pixel_layer_blend

`default_nettype wire

FILE: rtl/plb_checker.sv
// ----------------------------------------------------------------------------
// plb_checker
// Port-level checks on the pixel layer blend pipeline: result hold under
// stall, full rate when the sink is ready, stall cause and latency.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i
);

  // Hold a pending result until it is transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before transfer");

  // Accept a pixel in every cycle while the sink takes results
  a_full_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output ready");

  // Stall the input only when a result is backed up
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // Present the result via both stage registers when not stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after unstalled latency");

endmodule : plb_checker

bind pixel_layer_blend plb_checker u_plb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

`default_nettype wire
